// ===== hw/rtl/bwlp6_pkg.sv =====
// Shared constants, types and the fixed coefficient table of the sixth-order
// Butterworth low-pass filter. No dependencies; used by bwlp6_mac and the top level.
package bwlp6_pkg;

    localparam int ORDER           = 6;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FB_FRAC         = 57;
    localparam int FF_SCALE        = 90;
    localparam int ACC_FRAC        = 97;
    localparam int HIST_FRAC       = 40;

    localparam int ACC_W    = 128;
    localparam int HIST_W   = 64;
    localparam int FF_SHIFT = ACC_FRAC - FF_SCALE;
    localparam int Y_SHIFT  = ACC_FRAC - HIST_FRAC;

    // Thirteen products per word: b0..b6 on the inputs, a0..a5 on the outputs.
    localparam int NTERMS    = 2 * ORDER + 1;
    localparam int TERM_W    = $clog2(NTERMS);
    localparam int LAST_TERM = NTERMS - 1;

    // History memories are a power of two deep, so the ring index wraps freely.
    localparam int HIST_DEPTH = 2 ** $clog2(ORDER);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int CNT_W = 3;

    // Partial products per term: two for a feedforward tap, four for feedback.
    localparam logic [1:0] PART_FF_LAST = 2'd1;
    localparam logic [1:0] PART_FB_LAST = 2'd3;

    typedef struct packed {
        logic       clear;
        logic       issue;
        logic       ff;
        logic [1:0] part;
        logic       scale;
    } t_mac_ctl;

    // round(mant * 2^frac / 10^ex) by restoring long division at elaboration.
    function automatic logic [63:0] scale_dec(input logic [63:0] mant, input int ex,
                                              input int frac);
        logic [255:0] den;
        logic [255:0] num;
        logic [255:0] rem;
        logic [255:0] quo;
        den = 256'd1;
        for (int i = 0; i < ex; i++) begin
            den = (den << 3) + (den << 1);
        end
        num = 256'(mant) << (frac + 1);
        rem = '0;
        quo = '0;
        for (int i = 255; i >= 0; i--) begin
            rem = {rem[254:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return 64'((quo + 256'd1) >> 1);
    endfunction

    localparam logic [63:0] COEF [NTERMS] = '{
        scale_dec(64'd2759597545773583, 26, FF_SCALE),
        scale_dec(64'd165575852746415,  24, FF_SCALE),
        scale_dec(64'd413939631866037,  24, FF_SCALE),
        scale_dec(64'd551919509154,     21, FF_SCALE),
        scale_dec(64'd41393963186,      20, FF_SCALE),
        scale_dec(64'd16557585274,      20, FF_SCALE),
        scale_dec(64'd2759597545773583, 26, FF_SCALE),
        -scale_dec(64'd5864155410764718, 15, FB_FRAC),
        scale_dec(64'd1432997320081044,  14, FB_FRAC),
        -scale_dec(64'd1867794553054013, 14, FB_FRAC),
        scale_dec(64'd1369556264791875,  14, FB_FRAC),
        -scale_dec(64'd5356404254274295, 15, FB_FRAC),
        scale_dec(64'd8729693486160918,  16, FB_FRAC)
    };

endpackage

// ===== hw/rtl/bwlp6_mac.sv =====
// Shared 33x33 signed multiplier and 128-bit accumulator of the Butterworth filter.
// Depends on bwlp6_pkg for widths and the t_mac_ctl control bundle.
module bwlp6_mac import bwlp6_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [HIST_W-1:0] i_coef,
    input  logic [HIST_W-1:0] i_data,
    output logic [ACC_W-1:0]  o_acc
);

    localparam int HALF = HIST_W / 2;
    localparam int PW   = HALF + 1;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_HALF = 2'd1,
        SH_FULL = 2'd2
    } t_shift;

    logic signed [PW-1:0]   mul_a;
    logic signed [PW-1:0]   mul_b;
    logic signed [2*PW-1:0] prod_c;
    t_shift                 sh_c;

    logic signed [2*PW-1:0] r_prod;
    t_shift                 r_sh;
    logic                   r_neg;
    logic                   r_pv;
    logic [ACC_W-1:0]       r_acc;

    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] sum;

    logic signed [PW-1:0] a_lo, a_hi, d_lo, d_hi, d_s;

    assign a_lo = $signed({1'b0, i_coef[HALF-1:0]});
    assign a_hi = $signed({i_coef[HIST_W-1], i_coef[HIST_W-1:HALF]});
    assign d_lo = $signed({1'b0, i_data[HALF-1:0]});
    assign d_hi = $signed({i_data[HIST_W-1], i_data[HIST_W-1:HALF]});
    assign d_s  = $signed(i_data[PW-1:0]);

    // A feedforward sample fits in 33 signed bits, so only the coefficient is split.
    always_comb begin
        mul_a = a_lo;
        mul_b = d_lo;
        sh_c  = SH_NONE;
        if (i_ctl.ff) begin
            mul_b = d_s;
            if (i_ctl.part != 2'd0) begin
                mul_a = a_hi;
                sh_c  = SH_HALF;
            end
        end else begin
            case (i_ctl.part)
                2'd0: begin
                    mul_a = a_lo;
                    mul_b = d_lo;
                    sh_c  = SH_NONE;
                end
                2'd1: begin
                    mul_a = a_lo;
                    mul_b = d_hi;
                    sh_c  = SH_HALF;
                end
                2'd2: begin
                    mul_a = a_hi;
                    mul_b = d_lo;
                    sh_c  = SH_HALF;
                end
                default: begin
                    mul_a = a_hi;
                    mul_b = d_hi;
                    sh_c  = SH_FULL;
                end
            endcase
        end
    end

    assign prod_c = mul_a * mul_b;

    always_comb begin
        case (r_sh)
            SH_NONE: addend = ACC_W'(r_prod);
            SH_HALF: addend = ACC_W'(r_prod) << HALF;
            SH_FULL: addend = ACC_W'(r_prod) << HIST_W;
            default: addend = '0;
        endcase
        if (!r_pv) begin
            sum = r_acc;
        end else if (r_neg) begin
            sum = r_acc - addend;
        end else begin
            sum = r_acc + addend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        r_sh   <= sh_c;
        r_neg  <= !i_ctl.ff;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.scale) begin
            r_acc <= sum << FF_SHIFT;
        end else begin
            r_acc <= sum;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/butterworth_lowpass_iir6.sv =====
// Sixth-order Butterworth low-pass IIR filter, direct form I, fixed coefficients.
// Depends on bwlp6_pkg and bwlp6_mac (shared multiplier and accumulator).
//
// Each input word carries one signed sample and a restart flag and produces exactly
// one filtered, rounded and saturated output word. Words are processed one at a time:
// a new word is taken only in the idle state, so the filter cannot take the next word
// before it is through with the last one. The single 33x33 multiplier forms each
// feedforward product in two passes and each 64x64 feedback product in four; between
// the feedforward and feedback terms the sum is scaled, and after them the result is
// drained, rounded and written back; the write-back waits for a free output register.
// The input and output histories live in two small synchronous memories used as
// rings; a history entry is read the cycle before its products are formed and the new
// sample and output are written back once the word is finished. A restart (or reset)
// marks the whole history as empty: a count of stored samples gates every read, so
// entries older than the last restart read as zero and no clearing pass is needed.
// The output register decouples the two sides, so a new word is accepted while the
// previous result still waits to be taken.
module butterworth_lowpass_iir6 import bwlp6_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_filtered
);

    // Width of the rounded output before it is clamped to the sample range.
    localparam int OUT_W = HIST_W + 1 - HIST_FRAC;
    localparam int CW    = ((OUT_W > SAMPLE_BITS) ? OUT_W : SAMPLE_BITS) + 1;
    localparam int Y_Q_W = ACC_W - Y_SHIFT;
    localparam logic signed [CW-1:0] SMAX = CW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] SMIN = -SMAX - CW'(1);
    localparam logic [CNT_W-1:0]     CNT_MAX = '1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_SHIFT = 6'b000100,
        S_DRAIN = 6'b001000,
        S_ROUND = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [TERM_W-1:0] r_term, n_term;
    logic [1:0]        r_part, n_part;
    logic [CNT_W-1:0]  r_cnt;
    logic [HIST_AW-1:0] r_wr;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [HIST_W-1:0] r_y;
    logic              r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;

    // History rings: one entry per past word, newest just below the write pointer.
    logic [SAMPLE_BITS-1:0] xmem [HIST_DEPTH];
    logic [HIST_W-1:0]      ymem [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] r_xrd;
    logic [HIST_W-1:0]      r_yrd;

    t_mac_ctl          mac_ctl;
    logic [HIST_W-1:0] mac_data;
    logic [ACC_W-1:0]  acc;

    logic               is_ff;
    logic               last_part;
    logic               out_free;
    logic               wr_fire;
    logic [HIST_AW-1:0] rd_addr;
    logic               hist_ok;

    logic [ACC_W-1:0]  y_rnd;
    logic [Y_Q_W-1:0]  y_q;
    logic [HIST_W-1:0] y_sat;
    logic [HIST_W:0]   o_rnd;
    logic signed [OUT_W-1:0] o_q;
    logic signed [CW-1:0]    o_ext;
    logic signed [CW-1:0]    o_clamp;

    // Age in the history (0 is the newest) that a product term reads.
    function automatic logic [HIST_AW-1:0] age_of(input logic [TERM_W-1:0] t);
        if (t <= TERM_W'(ORDER)) begin
            return HIST_AW'(t - TERM_W'(1));
        end
        return HIST_AW'(t - TERM_W'(ORDER + 1));
    endfunction

    function automatic logic [HIST_W-1:0] sext(input logic [SAMPLE_BITS-1:0] v);
        return {{(HIST_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_filtered = r_filtered;

    assign is_ff     = (r_term <= TERM_W'(ORDER));
    assign last_part = is_ff ? (r_part == PART_FF_LAST) : (r_part == PART_FB_LAST);
    assign out_free  = !r_out_valid || !i_stall;
    assign wr_fire   = (r_state == S_WRITE) && out_free;

    // The read address follows the next term, so the data sits in the read register
    // during the cycles in which that term's products are formed.
    assign rd_addr = r_wr - HIST_AW'(1) - age_of(n_term);
    assign hist_ok = (age_of(r_term) < r_cnt);

    always_comb begin
        if (r_term == '0) begin
            mac_data = sext(r_x);
        end else if (!hist_ok) begin
            mac_data = '0;
        end else if (is_ff) begin
            mac_data = sext(r_xrd);
        end else begin
            mac_data = r_yrd;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_term        = r_term;
        n_part        = r_part;
        mac_ctl       = '0;
        mac_ctl.ff    = is_ff;
        mac_ctl.part  = r_part;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state       = S_MAC;
                    n_term        = '0;
                    n_part        = '0;
                    mac_ctl.clear = 1'b1;
                end
            end
            S_MAC: begin
                mac_ctl.issue = 1'b1;
                if (last_part) begin
                    n_part = '0;
                    if (r_term == TERM_W'(LAST_TERM)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_term = r_term + TERM_W'(1);
                        if (r_term == TERM_W'(ORDER)) begin
                            n_state = S_SHIFT;
                        end
                    end
                end else begin
                    n_part = r_part + 2'd1;
                end
            end
            S_SHIFT: begin
                // The feedforward sum is complete: bring it to the accumulator scale.
                mac_ctl.scale = 1'b1;
                n_state       = S_MAC;
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    bwlp6_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (COEF[r_term]),
        .i_data  (mac_data),
        .o_acc   (acc)
    );

    // New output history value: round half up at 40 fractional bits, saturate to 64.
    assign y_rnd = acc + (ACC_W'(1) << (Y_SHIFT - 1));
    assign y_q   = y_rnd[ACC_W-1:Y_SHIFT];

    always_comb begin
        if ((&y_q[Y_Q_W-1:HIST_W-1]) || !(|y_q[Y_Q_W-1:HIST_W-1])) begin
            y_sat = y_q[HIST_W-1:0];
        end else if (y_q[Y_Q_W-1]) begin
            y_sat = {1'b1, {(HIST_W - 1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(HIST_W - 1){1'b1}}};
        end
    end

    // Output word: round the history value to an integer and clamp to the sample range.
    assign o_rnd = {r_y[HIST_W-1], r_y} + ((HIST_W + 1)'(1) << (HIST_FRAC - 1));
    assign o_q   = $signed(o_rnd[HIST_W:HIST_FRAC]);
    assign o_ext = CW'(o_q);

    always_comb begin
        if (o_ext > SMAX) begin
            o_clamp = SMAX;
        end else if (o_ext < SMIN) begin
            o_clamp = SMIN;
        end else begin
            o_clamp = o_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            xmem[r_wr] <= r_x;
            ymem[r_wr] <= r_y;
        end
        r_xrd <= xmem[rd_addr];
        r_yrd <= ymem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= '0;
            r_part      <= '0;
            r_cnt       <= '0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_part  <= n_part;
            if (r_state == S_IDLE && i_valid && i_restart) begin
                r_cnt <= '0;
            end else if (wr_fire && r_cnt != CNT_MAX) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (wr_fire) begin
                r_wr <= r_wr + HIST_AW'(1);
            end
            if (wr_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_x <= i_sample;
        end
        if (r_state == S_ROUND) begin
            r_y <= y_sat;
        end
        if (wr_fire) begin
            r_filtered <= SAMPLE_BITS'(o_clamp);
        end
    end

endmodule

// ===== dv/bwlp6_response_check.sv =====
`timescale 1ns / 1ps
// Response checker for the sixth-order Butterworth low-pass filter: predicts each
// filtered word from the accepted input words and compares it. Depends on bwlp6_pkg.
module bwlp6_response_check import bwlp6_pkg::*; #(
    parameter int SB = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [SB-1:0] i_in_sample,
    input  logic                 i_in_restart,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [SB-1:0] i_out_filtered,
    output int                   o_mismatches,
    output int                   o_pending
);

    localparam logic signed [127:0] HIST_MAX = 128'sh7fff_ffff_ffff_ffff;
    localparam logic signed [127:0] HIST_MIN = -HIST_MAX - 128'sd1;
    localparam logic signed [127:0] OUT_MAX  = (128'sd1 <<< (SB - 1)) - 128'sd1;
    localparam logic signed [127:0] OUT_MIN  = -OUT_MAX - 128'sd1;
    localparam int                  REPORT_LIMIT = 10;

    longint               ff_coef [ORDER + 1];
    longint               fb_coef [ORDER];
    logic signed [63:0]   past_in [ORDER];
    logic signed [63:0]   past_out [ORDER];
    logic signed [SB-1:0] filtered_q [$];
    int                   mismatches = 0;

    // Rounds mant / 10^ex * 2^frac to the nearest integer.
    function automatic longint to_fixed(input longint unsigned mant, input int ex,
                                        input int frac);
        logic [255:0] den;
        logic [255:0] quo;
        den = 256'd1;
        repeat (ex) den = den * 256'd10;
        quo = (256'(mant) << (frac + 1)) / den;
        return longint'((quo[63:0] + 64'd1) >> 1);
    endfunction

    initial begin
        ff_coef[0] = to_fixed(64'd2759597545773583, 26, FF_SCALE);
        ff_coef[1] = to_fixed(64'd165575852746415, 24, FF_SCALE);
        ff_coef[2] = to_fixed(64'd413939631866037, 24, FF_SCALE);
        ff_coef[3] = to_fixed(64'd551919509154, 21, FF_SCALE);
        ff_coef[4] = to_fixed(64'd41393963186, 20, FF_SCALE);
        ff_coef[5] = to_fixed(64'd16557585274, 20, FF_SCALE);
        ff_coef[6] = ff_coef[0];
        fb_coef[0] = -to_fixed(64'd5864155410764718, 15, FB_FRAC);
        fb_coef[1] = to_fixed(64'd1432997320081044, 14, FB_FRAC);
        fb_coef[2] = -to_fixed(64'd1867794553054013, 14, FB_FRAC);
        fb_coef[3] = to_fixed(64'd1369556264791875, 14, FB_FRAC);
        fb_coef[4] = -to_fixed(64'd5356404254274295, 15, FB_FRAC);
        fb_coef[5] = to_fixed(64'd8729693486160918, 16, FB_FRAC);
    end

    function automatic logic signed [127:0] mul_wide(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < ORDER; i++) begin
            past_in[i]  = '0;
            past_out[i] = '0;
        end
    endfunction

    // One filter step; updates the history and returns the rounded, clamped sample.
    function automatic logic signed [SB-1:0] next_filtered(input logic signed [SB-1:0] smp,
                                                           input logic restart);
        logic signed [127:0] acc;
        logic signed [127:0] wide;
        logic signed [63:0]  x;
        logic signed [63:0]  y;
        if (restart)
            clear_history();
        x   = smp;
        acc = mul_wide(ff_coef[0], x);
        for (int i = 0; i < ORDER; i++)
            acc = acc + mul_wide(ff_coef[i + 1], past_in[i]);
        acc = acc <<< FF_SHIFT;
        for (int i = 0; i < ORDER; i++)
            acc = acc - mul_wide(fb_coef[i], past_out[i]);
        wide = (acc + (128'sd1 <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
        if (wide > HIST_MAX)
            y = HIST_MAX[63:0];
        else if (wide < HIST_MIN)
            y = HIST_MIN[63:0];
        else
            y = wide[63:0];
        for (int i = ORDER - 1; i > 0; i--) begin
            past_in[i]  = past_in[i - 1];
            past_out[i] = past_out[i - 1];
        end
        past_in[0]  = x;
        past_out[0] = y;
        wide = y;
        wide = (wide + (128'sd1 <<< (HIST_FRAC - 1))) >>> HIST_FRAC;
        if (wide > OUT_MAX)
            wide = OUT_MAX;
        else if (wide < OUT_MIN)
            wide = OUT_MIN;
        return wide[SB-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [SB-1:0] want;
        if (!i_rst_n) begin
            clear_history();
            filtered_q.delete();
        end else begin
            // Results leave before the word of this cycle enters.
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] unexpected output word %0d", $realtime,
                                 i_out_filtered);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_out_filtered !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("[%0t] filtered mismatch: expected %0d, got %0d",
                                     $realtime, want, i_out_filtered);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                filtered_q.push_back(next_filtered(i_in_sample, i_in_restart));
        end
        o_mismatches <= mismatches;
        o_pending    <= filtered_q.size();
    end

endmodule

// ===== dv/butterworth_lowpass_iir6_test.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the sixth-order Butterworth low-pass filter: clock, reset,
// stimulus and verdict. Depends on bwlp6_pkg, bwlp6_response_check and the filter RTL.
module butterworth_lowpass_iir6_test;
    import bwlp6_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam logic signed [SB-1:0] FULL_POS = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] FULL_NEG = {1'b1, {(SB - 1){1'b0}}};
    localparam int TOTAL_WORDS    = 1600;
    localparam int PHASE_WORDS    = 200;
    // Far above the time a word takes, so long random stalls have ample room.
    localparam int WATCHDOG_LIMIT = 4000;
    // A quiet spell at the end, longer than a word takes to pass the filter,
    // shows that no stray word follows.
    localparam int DRAIN_CYCLES   = 100;

    // Idling mixes: which side of the filter holds back, and how often.
    typedef enum int {
        PH_QUIET,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_valid   = 1'b0;
    logic signed [SB-1:0] i_sample  = '0;
    logic                 i_restart = 1'b0;
    logic                 i_stall   = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [SB-1:0] o_filtered;

    int mismatches;
    int pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int sent         = 0;

    always #4 i_clk = ~i_clk;

    butterworth_lowpass_iir6 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_filtered (o_filtered)
    );

    bwlp6_response_check #(.SB(SB)) scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_sample    (i_sample),
        .i_in_restart   (i_restart),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_out_filtered (o_filtered),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // The receiver stalls at random, at the rate the current phase sets.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // The watchdog ends the run when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** butterworth_lowpass_iir6: FAILED **");
            $finish;
        end
    end

    task automatic set_phase(input t_idle_phase phase);
        case (phase)
            PH_QUIET: begin
                idle_pct = 0;
                stall_pct <= 0;
            end
            PH_SENDER_IDLE: begin
                idle_pct = 60;
                stall_pct <= 0;
            end
            PH_RECEIVER_STALL: begin
                idle_pct = 0;
                stall_pct <= 60;
            end
            default: begin
                idle_pct = 34;
                stall_pct <= 34;
            end
        endcase
    endtask

    // Offers one word, after a random number of idle cycles, and returns once the
    // filter has taken it. Valid stays high into the next word when no gap follows,
    // so it is never lowered and raised within one edge.
    task automatic send_word(input logic signed [SB-1:0] value, input logic restart);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample  <= value;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    // Holds the sender off until every predicted result has been taken.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [SB-1:0] level;
        logic                 restart;
        int                   kind;
        int                   len;
        int                   half;
        bit                   paused;
        paused = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words. The very first word runs on the history left by reset, then
        // a restart comes on its own and twice in a row, then the full-scale values,
        // the smallest steps around zero and alternating bit patterns.
        set_phase(PH_QUIET);
        send_word('0, 1'b0);
        send_word(FULL_POS, 1'b1);
        send_word(FULL_POS, 1'b1);
        send_word(FULL_NEG, 1'b0);
        send_word(FULL_NEG, 1'b0);
        send_word(SB'(-1), 1'b0);
        send_word(SB'(1), 1'b0);
        send_word(FULL_POS, 1'b0);
        send_word(FULL_NEG, 1'b0);
        send_word(24'sh555555, 1'b0);
        send_word(24'shAAAAAA, 1'b0);
        send_word('0, 1'b1);
        send_word(FULL_NEG, 1'b1);
        repeat (6) send_word(FULL_NEG, 1'b0);
        send_word(FULL_POS, 1'b1);
        repeat (4) send_word(FULL_POS, 1'b0);
        wait_for_results();

        // Random part, made of segments. Long constant levels let the filter settle
        // and then overshoot on the next step, which is what drives the output into
        // saturation; short square waves and raw noise fill the rest.
        sent = 0;
        while (sent < TOTAL_WORDS) begin
            set_phase(t_idle_phase'((sent / PHASE_WORDS) % 4));
            if (!paused && sent >= TOTAL_WORDS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            kind    = $urandom_range(0, 9);
            restart = ($urandom_range(0, 3) == 0);
            if (kind < 5) begin
                case ($urandom_range(0, 3))
                    0:       level = FULL_POS;
                    1:       level = FULL_NEG;
                    2:       level = '0;
                    default: level = SB'($urandom);
                endcase
                len = $urandom_range(150, 400);
                for (int k = 0; k < len && sent < TOTAL_WORDS; k++) begin
                    send_word(level, restart);
                    restart = 1'b0;
                end
            end else if (kind < 8) begin
                len = $urandom_range(20, 80);
                for (int k = 0; k < len && sent < TOTAL_WORDS; k++)
                    send_word(SB'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                half = $urandom_range(1, 24);
                len  = $urandom_range(40, 160);
                for (int k = 0; k < len && sent < TOTAL_WORDS; k++) begin
                    send_word(((k / half) % 2) ? FULL_NEG : FULL_POS, restart);
                    restart = 1'b0;
                end
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("** butterworth_lowpass_iir6: PASSED **");
        else
            $display("** butterworth_lowpass_iir6: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bwlp6_pkg.sv
hw/rtl/bwlp6_mac.sv
hw/rtl/butterworth_lowpass_iir6.sv
dv/bwlp6_response_check.sv
dv/butterworth_lowpass_iir6_test.sv
